[hw/rtl/frs_pkg.sv]
`timescale 1ns / 1ps
package frs_pkg;

    localparam int FAULT_COUNT   = 32;
    localparam int HISTORY_DEPTH = 16;
    localparam int PERS_SLOTS    = 32;
    localparam int PERS_CAP      = (FAULT_COUNT < PERS_SLOTS) ? FAULT_COUNT : PERS_SLOTS;

    localparam int HIST_AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int HIST_FW = $clog2(HISTORY_DEPTH + 1);
    localparam int PERS_AW = $clog2(PERS_SLOTS);

    localparam logic [1:0] OP_STORE     = 2'd0;
    localparam logic [1:0] OP_READ_HIST = 2'd1;
    localparam logic [1:0] OP_READ_PERS = 2'd2;

    localparam logic [1:0] REG_PERSISTENT_MASK = 2'd0;
    localparam logic [1:0] REG_ACTIVE_MASK     = 2'd1;

    typedef struct packed {
        logic [4:0]  id;
        logic [7:0]  status;
        logic [7:0]  qualifier;
        logic [63:0] boot;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

endpackage

[hw/rtl/frs_ram.sv]
`timescale 1ns / 1ps
module frs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hw/rtl/fault_record_store.sv]
`timescale 1ns / 1ps
// Channel  | Signals                                         | Direction
// in       | in_valid/in_ready, opcode..boot_cycle_in        | item in
// out      | out_valid/out_ready, error..persistent_fill     | item out
// cfg      | cfg_valid/cfg_ready, cfg_index, cfg_data        | register write
//
// One item at a time. A read of an entry below the fill waits for the RAM read
// data; an out-of-range read, rejected store, unused opcode or non-persistent
// store goes to the output register directly. A persistent store scans slots,
// then updates, inserts if not full, or clears; a clear shifts each later slot
// down, so no slot is both scanned and shifted. The persistent RAM's single
// read port and registered read set this. Reset clears fills, head and the
// persistent mask and sets the active mask to 1; the RAMs are not cleared. A
// new item is taken while the previous result waits in the output register.
module fault_record_store
    import frs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [15:0] fault_id,
    input  logic [4:0]  entry_index,
    input  logic [7:0]  status_in,
    input  logic [7:0]  qualifier_in,
    input  logic [63:0] boot_cycle_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        error,
    output logic        entry_valid,
    output logic [4:0]  id_out,
    output logic [7:0]  status_out,
    output logic [7:0]  qualifier_out,
    output logic [63:0] boot_cycle_out,
    output logic [4:0]  history_fill,
    output logic [5:0]  persistent_fill,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HWAIT = 4'd1;  // history read data arriving
    localparam logic [3:0] S_PWAIT = 4'd2;  // persistent read data arriving
    localparam logic [3:0] S_SRD   = 4'd3;  // scan: issue slot read
    localparam logic [3:0] S_SCMP  = 4'd4;  // scan: compare id
    localparam logic [3:0] S_ACT   = 4'd5;  // insert / update / start removal
    localparam logic [3:0] S_SHRD  = 4'd6;  // shift: read slot+1
    localparam logic [3:0] S_SHWR  = 4'd7;  // shift: write slot
    localparam logic [3:0] S_DONE  = 4'd8;  // result to output register

    localparam logic [5:0] CAP6 = 6'(PERS_CAP);

    logic [3:0]         state_reg;
    logic [HIST_AW-1:0] hist_head_reg;
    logic [HIST_FW-1:0] hist_fill_reg;
    logic [5:0]         pers_fill_reg;
    logic [PERS_AW-1:0] scan_reg;
    logic               found_reg;
    logic               out_valid_reg;
    logic [31:0]        pmask_reg;
    logic [7:0]         amask_reg;

    logic [4:0]  id5_reg;
    logic [7:0]  st_reg;
    logic [7:0]  q_reg;
    logic [63:0] b_reg;
    logic        pend_err_reg;
    logic        pend_vld_reg;
    rec_t        pend_rec_reg;
    logic        out_err_reg;
    logic        out_vld_reg;
    rec_t        out_rec_reg;
    logic [4:0]  out_hfill_reg;
    logic [5:0]  out_pfill_reg;

    logic accept, store_ok, store_pers, hist_ok, pers_ok, out_load, inactive;
    logic [9:0] hk;
    logic [6:0] scan_p1, scan_p2;

    logic               h_wr_en, h_rd_en;
    logic [HIST_AW-1:0] h_rd_addr;
    rec_t               h_wr_data, h_rd_data;
    logic               p_wr_en, p_rd_en;
    logic [PERS_AW-1:0] p_wr_addr, p_rd_addr;
    rec_t               p_wr_data, p_rd_data;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    assign store_ok   = (opcode == OP_STORE) && (17'(fault_id) < 17'(FAULT_COUNT));
    assign store_pers = (fault_id < 16'd32) && pmask_reg[fault_id[4:0]];
    assign hist_ok    = 9'(entry_index) < 9'(hist_fill_reg);
    assign pers_ok    = {1'b0, entry_index} < pers_fill_reg;
    assign inactive   = (st_reg & amask_reg) == 8'd0;
    assign scan_p1    = 7'(scan_reg) + 7'd1;
    assign scan_p2    = 7'(scan_reg) + 7'd2;

    // age 0 is the slot just behind head; idx < fill <= depth keeps this in range
    always_comb
    begin
        hk = 10'(hist_head_reg) + 10'(HISTORY_DEPTH - 1) - 10'(entry_index);
        if (hk >= 10'(HISTORY_DEPTH))
        begin
            hk = hk - 10'(HISTORY_DEPTH);
        end
    end

    assign h_wr_en   = accept && store_ok;
    assign h_wr_data = '{id: fault_id[4:0], status: status_in, qualifier: qualifier_in,
                         boot: boot_cycle_in};
    assign h_rd_en   = accept && (opcode == OP_READ_HIST);
    assign h_rd_addr = hk[HIST_AW-1:0];

    always_comb
    begin
        p_rd_en   = 1'b0;
        p_rd_addr = scan_reg;
        p_wr_en   = 1'b0;
        p_wr_addr = scan_reg;
        p_wr_data = '{id: id5_reg, status: st_reg, qualifier: q_reg, boot: b_reg};
        unique case (state_reg)
            S_IDLE:
            begin
                p_rd_en   = accept && (opcode == OP_READ_PERS);
                p_rd_addr = entry_index[PERS_AW-1:0];
            end
            S_SRD:
            begin
                p_rd_en = 1'b1;
            end
            S_SHRD:
            begin
                p_rd_en   = 1'b1;
                p_rd_addr = scan_p1[PERS_AW-1:0];
            end
            S_SHWR:
            begin
                p_wr_en   = 1'b1;
                p_wr_data = p_rd_data;
            end
            S_ACT:
            begin
                if (!inactive)
                begin
                    if (found_reg)
                    begin
                        p_wr_en = 1'b1;
                    end
                    else if (pers_fill_reg < CAP6)
                    begin
                        p_wr_en   = 1'b1;
                        p_wr_addr = pers_fill_reg[PERS_AW-1:0];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    frs_ram #(.WIDTH(REC_W), .DEPTH(HISTORY_DEPTH)) u_hist_ram (
        .clk     (clk),
        .wr_en   (h_wr_en),
        .wr_addr (hist_head_reg),
        .wr_data (h_wr_data),
        .rd_en   (h_rd_en),
        .rd_addr (h_rd_addr),
        .rd_data (h_rd_data)
    );

    frs_ram #(.WIDTH(REC_W), .DEPTH(PERS_SLOTS)) u_pers_ram (
        .clk     (clk),
        .wr_en   (p_wr_en),
        .wr_addr (p_wr_addr),
        .wr_data (p_wr_data),
        .rd_en   (p_rd_en),
        .rd_addr (p_rd_addr),
        .rd_data (p_rd_data)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hist_head_reg <= '0;
            hist_fill_reg <= '0;
            pers_fill_reg <= '0;
            scan_reg      <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            pmask_reg     <= '0;
            amask_reg     <= 8'd1;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_PERSISTENT_MASK: pmask_reg <= cfg_data;
                    REG_ACTIVE_MASK:     amask_reg <= cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_DONE;
                        if (store_ok)
                        begin
                            hist_head_reg <= (hist_head_reg == HIST_AW'(HISTORY_DEPTH - 1))
                                             ? '0 : hist_head_reg + 1'b1;
                            if (hist_fill_reg != HIST_FW'(HISTORY_DEPTH))
                            begin
                                hist_fill_reg <= hist_fill_reg + 1'b1;
                            end
                            if (store_pers)
                            begin
                                scan_reg  <= '0;
                                found_reg <= 1'b0;
                                state_reg <= (pers_fill_reg == 6'd0) ? S_ACT : S_SRD;
                            end
                        end
                        else if ((opcode == OP_READ_HIST) && hist_ok)
                        begin
                            state_reg <= S_HWAIT;
                        end
                        else if ((opcode == OP_READ_PERS) && pers_ok)
                        begin
                            state_reg <= S_PWAIT;
                        end
                    end
                end
                S_HWAIT, S_PWAIT:
                begin
                    state_reg <= S_DONE;
                end
                S_SRD:
                begin
                    state_reg <= S_SCMP;
                end
                S_SCMP:
                begin
                    if (p_rd_data.id == id5_reg)
                    begin
                        found_reg <= 1'b1;
                        state_reg <= S_ACT;
                    end
                    else if (scan_p1 == 7'(pers_fill_reg))
                    begin
                        state_reg <= S_ACT;
                    end
                    else
                    begin
                        scan_reg  <= scan_p1[PERS_AW-1:0];
                        state_reg <= S_SRD;
                    end
                end
                S_ACT:
                begin
                    state_reg <= S_DONE;
                    if (inactive)
                    begin
                        if (found_reg)
                        begin
                            if (scan_p1 < 7'(pers_fill_reg))
                            begin
                                state_reg <= S_SHRD;
                            end
                            else
                            begin
                                pers_fill_reg <= pers_fill_reg - 1'b1;
                            end
                        end
                    end
                    else if (!found_reg && (pers_fill_reg < CAP6))
                    begin
                        pers_fill_reg <= pers_fill_reg + 1'b1;
                    end
                end
                S_SHRD:
                begin
                    state_reg <= S_SHWR;
                end
                S_SHWR:
                begin
                    if (scan_p2 < 7'(pers_fill_reg))
                    begin
                        scan_reg  <= scan_p1[PERS_AW-1:0];
                        state_reg <= S_SHRD;
                    end
                    else
                    begin
                        pers_fill_reg <= pers_fill_reg - 1'b1;
                        state_reg     <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id5_reg      <= fault_id[4:0];
            st_reg       <= status_in;
            q_reg        <= qualifier_in;
            b_reg        <= boot_cycle_in;
            pend_err_reg <= (opcode == OP_STORE) && !store_ok;
            pend_vld_reg <= ((opcode == OP_READ_HIST) && hist_ok) ||
                            ((opcode == OP_READ_PERS) && pers_ok);
            pend_rec_reg <= '0;
        end
        if (state_reg == S_HWAIT)
        begin
            pend_rec_reg <= h_rd_data;
        end
        if (state_reg == S_PWAIT)
        begin
            pend_rec_reg <= p_rd_data;
        end
        if (out_load)
        begin
            out_err_reg   <= pend_err_reg;
            out_vld_reg   <= pend_vld_reg;
            out_rec_reg   <= pend_rec_reg;
            out_hfill_reg <= 5'(hist_fill_reg);
            out_pfill_reg <= pers_fill_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign error           = out_err_reg;
    assign entry_valid     = out_vld_reg;
    assign id_out          = out_rec_reg.id;
    assign status_out      = out_rec_reg.status;
    assign qualifier_out   = out_rec_reg.qualifier;
    assign boot_cycle_out  = out_rec_reg.boot;
    assign history_fill    = out_hfill_reg;
    assign persistent_fill = out_pfill_reg;

endmodule

[dv/fault_record_store_test.sv]
`timescale 1ns / 1ps
module fault_record_store_test;
    import frs_pkg::*;

    // Settle time: a store may scan and shift the whole persistent table.
    localparam int SETTLE_CYCLES = 200;
    localparam int STALL_LIMIT   = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [15:0] fault_id;
    logic [4:0]  entry_index;
    logic [7:0]  status_in;
    logic [7:0]  qualifier_in;
    logic [63:0] boot_cycle_in;
    logic        out_valid;
    logic        out_ready;
    logic        error;
    logic        entry_valid;
    logic [4:0]  id_out;
    logic [7:0]  status_out;
    logic [7:0]  qualifier_out;
    logic [63:0] boot_cycle_out;
    logic [4:0]  history_fill;
    logic [5:0]  persistent_fill;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    fault_record_store DUT (.*);

    // Expected result of one item.
    typedef struct {
        logic        error;
        logic        entry_valid;
        logic [4:0]  id;
        logic [7:0]  status;
        logic [7:0]  qualifier;
        logic [63:0] boot;
        logic [4:0]  history_fill;
        logic [5:0]  persistent_fill;
    } fault_result_t;

    fault_result_t expected_results[$];

    // Mirror of the store's contents and registers.
    logic [31:0] mirror_persistent_mask;
    logic [7:0]  mirror_active_mask;
    rec_t        mirror_hist[HISTORY_DEPTH];
    int unsigned mirror_hist_head;
    int unsigned mirror_hist_fill;
    rec_t        mirror_pers[PERS_SLOTS];
    int unsigned mirror_pers_fill;

    int  failures;
    int  idle_pct;          // chance per cycle that a side idles
    bit  hold_off_output;   // long receiver stall for the backpressure test
    int  quiet_cycles;
    int  hist_cursor;       // entry index used in the history wrap read-back

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: any cycle without a handshake on in, out or cfg counts toward the limit.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("fault_record_store test failed");
            $finish;
        end
    end

    // Receiver: random idling, plus the hold-off requested by the backpressure test.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !hold_off_output && ($urandom_range(99) >= idle_pct);
    end

    // Result checker.
    always @(posedge clk)
    begin
        fault_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no item pending");
                failures++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (error !== exp_r.error)
                begin
                    $error("error: expected %0d got %0d", exp_r.error, error);
                    failures++;
                end
                if (entry_valid !== exp_r.entry_valid)
                begin
                    $error("entry_valid: expected %0d got %0d", exp_r.entry_valid, entry_valid);
                    failures++;
                end
                if (id_out !== exp_r.id)
                begin
                    $error("id_out: expected %0d got %0d", exp_r.id, id_out);
                    failures++;
                end
                if (status_out !== exp_r.status)
                begin
                    $error("status_out: expected %0h got %0h", exp_r.status, status_out);
                    failures++;
                end
                if (qualifier_out !== exp_r.qualifier)
                begin
                    $error("qualifier_out: expected %0h got %0h", exp_r.qualifier,
                           qualifier_out);
                    failures++;
                end
                if (boot_cycle_out !== exp_r.boot)
                begin
                    $error("boot_cycle_out: expected %0h got %0h", exp_r.boot, boot_cycle_out);
                    failures++;
                end
                if (history_fill !== exp_r.history_fill)
                begin
                    $error("history_fill: expected %0d got %0d", exp_r.history_fill,
                           history_fill);
                    failures++;
                end
                if (persistent_fill !== exp_r.persistent_fill)
                begin
                    $error("persistent_fill: expected %0d got %0d", exp_r.persistent_fill,
                           persistent_fill);
                    failures++;
                end
            end
        end
    end

    // Apply one item to the mirror and return what the store should answer.
    function automatic fault_result_t predict_fault_item(logic [1:0] op, logic [15:0] fid,
                                                         logic [4:0] idx, logic [7:0] st,
                                                         logic [7:0] q, logic [63:0] b);
        fault_result_t r;
        rec_t rec;
        int found;
        int k;
        r = '{default: '0};
        rec = '{id: fid[4:0], status: st, qualifier: q, boot: b};
        found = -1;
        if (op == OP_STORE)
        begin
            if (fid >= FAULT_COUNT)
                r.error = 1'b1;
            else
            begin
                mirror_hist[mirror_hist_head] = rec;
                mirror_hist_head = (mirror_hist_head + 1) % HISTORY_DEPTH;
                if (mirror_hist_fill < HISTORY_DEPTH)
                    mirror_hist_fill++;
                if (fid < 32 && mirror_persistent_mask[fid])
                begin
                    for (int i = 0; i < mirror_pers_fill; i++)
                        if (found < 0 && mirror_pers[i].id == rec.id)
                            found = i;
                    if ((st & mirror_active_mask) == 0)
                    begin
                        // Cleared: drop the entry and close the gap.
                        if (found >= 0)
                        begin
                            for (int i = found; i + 1 < mirror_pers_fill; i++)
                                mirror_pers[i] = mirror_pers[i + 1];
                            mirror_pers_fill--;
                        end
                    end
                    else if (found >= 0)
                        mirror_pers[found] = rec;
                    else if (mirror_pers_fill < PERS_CAP)
                    begin
                        mirror_pers[mirror_pers_fill] = rec;
                        mirror_pers_fill++;
                    end
                end
            end
        end
        else if (op == OP_READ_HIST)
        begin
            if (idx < mirror_hist_fill)
            begin
                k = (mirror_hist_head + HISTORY_DEPTH - 1 - idx) % HISTORY_DEPTH;
                r.entry_valid = 1'b1;
                r.id = mirror_hist[k].id;
                r.status = mirror_hist[k].status;
                r.qualifier = mirror_hist[k].qualifier;
                r.boot = mirror_hist[k].boot;
            end
        end
        else if (op == OP_READ_PERS)
        begin
            if (idx < mirror_pers_fill)
            begin
                r.entry_valid = 1'b1;
                r.id = mirror_pers[idx].id;
                r.status = mirror_pers[idx].status;
                r.qualifier = mirror_pers[idx].qualifier;
                r.boot = mirror_pers[idx].boot;
            end
        end
        r.history_fill = 5'(mirror_hist_fill);
        r.persistent_fill = 6'(mirror_pers_fill);
        return r;
    endfunction

    // Offer one item, with a random idle gap first; predict it on acceptance.
    // Valid stays high after acceptance until the next gap or the next drain.
    task automatic send_item(logic [1:0] op, logic [15:0] fid, logic [4:0] idx,
                             logic [7:0] st, logic [7:0] q, logic [63:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        opcode        <= op;
        fault_id      <= fid;
        entry_index   <= idx;
        status_in     <= st;
        qualifier_in  <= q;
        boot_cycle_in <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_results.push_back(predict_fault_item(op, fid, idx, st, q, b));
    endtask

    function automatic logic [63:0] rand_boot();
        return {$urandom(), $urandom()};
    endfunction

    // Store with a random record; status chosen by the caller.
    task automatic store_fault(logic [15:0] fid, logic [7:0] st);
        send_item(OP_STORE, fid, 5'($urandom()), st, 8'($urandom()), rand_boot());
    endtask

    task automatic read_item(logic [1:0] op, logic [4:0] idx);
        send_item(op, 16'($urandom()), idx, 8'($urandom()), 8'($urandom()), rand_boot());
    endtask

    // Wait for every result, then let a store that may still be running finish.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write while the store is idle; mirror updated on acceptance.
    task automatic write_reg(logic [1:0] index, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (index == REG_PERSISTENT_MASK)
            mirror_persistent_mask = data;
        else if (index == REG_ACTIVE_MASK)
            mirror_active_mask = data[7:0];
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Edge values of every field, each opcode, rejected ids, the unused opcode.
    task automatic test_directed_edges();
        write_reg(REG_PERSISTENT_MASK, 32'hFFFF_FFFF);
        write_reg(REG_ACTIVE_MASK, 8'h01);
        read_item(OP_READ_HIST, 5'd0);              // empty ring
        read_item(OP_READ_PERS, 5'd0);              // empty table
        send_item(OP_STORE, 16'd0, 5'd31, 8'hFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_STORE, 16'd31, 5'd0, 8'h01, 8'h00, 64'h0);
        send_item(OP_STORE, 16'd32, 5'd0, 8'hFF, 8'hAA, 64'h1);    // rejected
        send_item(OP_STORE, 16'hFFFF, 5'd0, 8'hFF, 8'h55, 64'h2);  // rejected
        send_item(OP_STORE, 16'd5, 5'd0, 8'hFE, 8'h12, rand_boot()); // inactive, absent
        read_item(OP_READ_HIST, 5'd0);
        read_item(OP_READ_HIST, 5'd2);
        read_item(OP_READ_HIST, 5'd3);              // beyond fill
        read_item(OP_READ_HIST, 5'd31);
        read_item(OP_READ_PERS, 5'd0);
        read_item(OP_READ_PERS, 5'd1);
        read_item(OP_READ_PERS, 5'd31);
        store_fault(16'd31, 8'h03);                 // update in place
        store_fault(16'd0, 8'h00);                  // clear, shift down
        read_item(OP_READ_PERS, 5'd0);
        send_item(2'd3, 16'hFFFF, 5'h1F, 8'hFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(2'd3, 16'h0, 5'h0, 8'h0, 8'h0, 64'h0);
        drain();
    endtask

    // Ring wraps past its depth; each age read back newest first.
    task automatic test_history_wrap();
        for (int i = 0; i < HISTORY_DEPTH + 5; i++)
            store_fault(16'($urandom_range(FAULT_COUNT - 1)), 8'($urandom()));
        for (hist_cursor = 0; hist_cursor < 32; hist_cursor++)
            read_item(OP_READ_HIST, 5'(hist_cursor));
        drain();
    endtask

    // Fill the table to capacity, update an entry when full, then clear random entries.
    task automatic test_table_full();
        write_reg(REG_ACTIVE_MASK, 8'hFF);
        for (int i = 0; i < FAULT_COUNT; i++)
            store_fault(16'(i), 8'h80);
        store_fault(16'd3, 8'h40);                  // update when full
        for (int i = 0; i < 32; i++)
            read_item(OP_READ_PERS, 5'(i));
        drain();
        write_reg(REG_PERSISTENT_MASK, 32'hFFFF_FFFF);
        for (int i = 0; i < 16; i++)
            store_fault(16'($urandom_range(FAULT_COUNT - 1)), 8'h00);
        for (int i = 0; i < 32; i++)
            read_item(OP_READ_PERS, 5'(i));
        drain();
    endtask

    // Receiver stalls a long stretch while the sender keeps offering.
    task automatic test_output_backpressure();
        fork
            begin
                hold_off_output = 1'b1;
                repeat (300) @(posedge clk);
                hold_off_output = 1'b0;
            end
            for (int i = 0; i < 20; i++)
                read_item(2'($urandom_range(2)), 5'($urandom()));
        join
        drain();
    endtask

    // Random phase under one register setting: legal stores, mostly on a
    // small id set so the table churns, plus reads and some noise.
    task automatic random_phase(logic [31:0] pmask, logic [7:0] amask, int count);
        int pick;
        logic [15:0] fid;
        drain();
        write_reg(REG_PERSISTENT_MASK, pmask);
        write_reg(REG_ACTIVE_MASK, amask);
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                if ($urandom_range(3) == 0)
                    fid = 16'($urandom_range(FAULT_COUNT - 1));
                else
                    fid = 16'($urandom_range(7));
                store_fault(fid, 8'($urandom()));
            end
            else if (pick < 65)
                read_item(OP_READ_PERS, 5'($urandom()));
            else if (pick < 85)
                read_item(OP_READ_HIST, 5'($urandom()));
            else if (pick < 93)
                send_item(OP_STORE, 16'($urandom()), 5'($urandom()), 8'($urandom()),
                          8'($urandom()), rand_boot());
            else
                send_item(2'd3, 16'($urandom()), 5'($urandom()), 8'($urandom()),
                          8'($urandom()), rand_boot());
        end
        drain();
    endtask

    initial
    begin
        failures = 0;
        idle_pct = 38;
        hold_off_output = 1'b0;
        quiet_cycles = 0;
        in_valid = 1'b0;
        opcode = OP_STORE;
        fault_id = '0;
        entry_index = '0;
        status_in = '0;
        qualifier_in = '0;
        boot_cycle_in = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_PERSISTENT_MASK;
        cfg_data = '0;
        mirror_persistent_mask = '0;
        mirror_active_mask = 8'h01;
        mirror_hist_head = 0;
        mirror_hist_fill = 0;
        mirror_pers_fill = 0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_history_wrap();
        test_table_full();
        test_output_backpressure();

        random_phase(32'hFFFF_FFFF, 8'hFF, 250);
        random_phase(32'h0000_0000, 8'h01, 120);
        idle_pct = 0;                               // no idling at all here
        random_phase(32'h5555_00FF, 8'h80, 250);
        idle_pct = 38;
        random_phase(32'($urandom()), 8'($urandom_range(255, 1)), 200);
        random_phase(32'hAAAA_AAAA, 8'h01, 100);

        if (failures == 0)
            $display("fault_record_store test passed");
        else
            $display("fault_record_store test failed");
        $finish;
    end

endmodule

[files.f]
hw/rtl/frs_pkg.sv
hw/rtl/frs_ram.sv
hw/rtl/fault_record_store.sv
dv/fault_record_store_test.sv
